// ===== sv/vna_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the vertex normal accumulator
package vna_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] RDPOS_LAST = 6'd3;
  localparam logic [CNT_W-1:0] CROSS_LAST = 6'd6;
  localparam logic [CNT_W-1:0] RDSUM_LAST = 6'd1;
  localparam logic [CNT_W-1:0] SQ_LAST    = 6'd3;
  localparam logic [CNT_W-1:0] SQRT_LAST  = 6'd32;
  localparam logic [CNT_W-1:0] DIV_LAST   = 6'd18;
  localparam logic [CNT_W-1:0] ACC_LAST   = 6'd1;

  localparam logic [1:0] LAST_CORNER = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_WRITE,
    OP_RDPOS,
    OP_EDGE,
    OP_ESHIFT,
    OP_CROSS,
    OP_RDSUM,
    OP_PREP,
    OP_NORM,
    OP_SQ,
    OP_SQRT,
    OP_DIV,
    OP_ACC,
    OP_OUT_N,
    OP_OUT_DEF,
    OP_OUT_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       k;
    logic [CNT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic ok_first;
    logic ok_all;
    logic zero;
    logic norm_done;
  } dp_stat_t;

endpackage

// ===== sv/vna_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for the vertex normal accumulator
module vna_ctrl import vna_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] action,
  input  dp_stat_t   stat,
  output logic       busy,
  output logic       out_valid,
  output logic       out_status,
  output dp_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_WRITE  = 15'b000000000000010,
    S_RDPOS  = 15'b000000000000100,
    S_EDGE   = 15'b000000000001000,
    S_ESHIFT = 15'b000000000010000,
    S_CROSS  = 15'b000000000100000,
    S_RDSUM  = 15'b000000001000000,
    S_PREP   = 15'b000000010000000,
    S_NORM   = 15'b000000100000000,
    S_SQ     = 15'b000001000000000,
    S_SQRT   = 15'b000010000000000,
    S_DIV    = 15'b000100000000000,
    S_ACC    = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             read_r, read_nxt;
  logic             status_r, status_nxt;
  dp_op_t           osel_r, osel_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    read_nxt   = read_r;
    status_nxt = status_r;
    osel_nxt   = osel_r;
    cmd.op     = OP_NONE;
    cmd.k      = k_r;
    cmd.cnt    = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LATCH;
          cnt_nxt    = '0;
          k_nxt      = '0;
          read_nxt   = (action == ACT_READ);
          status_nxt = 1'b0;
          osel_nxt   = OP_OUT_ZERO;
          if (action == ACT_WRITE && stat.ok_first) begin
            state_nxt = S_WRITE;
          end else if (action == ACT_TRI && stat.ok_all) begin
            state_nxt = S_RDPOS;
          end else if (action == ACT_READ && stat.ok_first) begin
            state_nxt = S_RDSUM;
          end else begin
            status_nxt = 1'b1;
            state_nxt  = S_FIN;
          end
        end
      end
      S_WRITE: begin
        cmd.op    = OP_WRITE;
        state_nxt = S_FIN;
      end
      S_RDPOS: begin
        cmd.op = OP_RDPOS;
        if (cnt_r == RDPOS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_EDGE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EDGE: begin
        cmd.op    = OP_EDGE;
        state_nxt = S_ESHIFT;
      end
      S_ESHIFT: begin
        cmd.op    = OP_ESHIFT;
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (cnt_r == CROSS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_PREP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RDSUM: begin
        cmd.op = OP_RDSUM;
        if (cnt_r == RDSUM_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_PREP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PREP: begin
        cmd.op = OP_PREP;
        if (stat.zero) begin
          osel_nxt  = read_r ? OP_OUT_DEF : OP_OUT_ZERO;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (stat.norm_done) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == SQRT_LAST) begin
          cnt_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          if (k_r == LAST_CORNER) begin
            k_nxt = '0;
            if (read_r) begin
              osel_nxt  = OP_OUT_N;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_ACC;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (cnt_r == ACC_LAST) begin
          cnt_nxt = '0;
          if (k_r == LAST_CORNER) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.op    = osel_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      k_r      <= '0;
      read_r   <= 1'b0;
      status_r <= 1'b0;
      osel_r   <= OP_OUT_ZERO;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      read_r   <= read_nxt;
      status_r <= status_nxt;
      osel_r   <= osel_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign out_status = status_r;

endmodule

// ===== sv/vna_dp.sv =====
`timescale 1ns / 1ps
// datapath: vertex stores, config register, multiplier, square root and divider
module vna_dp import vna_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [9:0]         first_index,
  input  logic [9:0]         second_index,
  input  logic [9:0]         third_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z
);

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CMP_W  = ($clog2(MAX_VERTICES + 1) > 11) ? $clog2(MAX_VERTICES + 1) : 11;
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  function automatic logic idx_ok(input logic [9:0] idx, input logic [10:0] vc);
    idx_ok = (CMP_W'(idx) < CMP_W'(MAX_VERTICES)) && (CMP_W'(idx) < CMP_W'(vc));
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [17:0] b);
    logic signed [32:0] t;
    t = $signed({a[31], a}) + $signed({{15{b[17]}}, b});
    if (t[32] != t[31]) begin
      sat_add = t[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      sat_add = t[31:0];
    end
  endfunction

  // config and latched item
  logic [10:0]        vcount_r, vcount_nxt;
  logic [9:0]         idx_r [3];
  logic [9:0]         idx_nxt [3];
  logic signed [31:0] wx_r, wy_r, wz_r, wx_nxt, wy_nxt, wz_nxt;

  // memories
  logic signed [31:0] pos_x_mem [MAX_VERTICES];
  logic signed [31:0] pos_y_mem [MAX_VERTICES];
  logic signed [31:0] pos_z_mem [MAX_VERTICES];
  logic signed [31:0] sum_x_mem [MAX_VERTICES];
  logic signed [31:0] sum_y_mem [MAX_VERTICES];
  logic signed [31:0] sum_z_mem [MAX_VERTICES];
  logic signed [31:0] pos_x_q_r, pos_y_q_r, pos_z_q_r;
  logic signed [31:0] sum_x_q_r, sum_y_q_r, sum_z_q_r;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               pos_we, sum_we;
  logic signed [31:0] sum_x_wd, sum_y_wd, sum_z_wd;
  logic [1:0]         rd_corner;

  // arithmetic state
  logic signed [31:0] px_r [3], py_r [3], pz_r [3];
  logic signed [31:0] px_nxt [3], py_nxt [3], pz_nxt [3];
  logic signed [32:0] e_r [6], e_nxt [6];
  logic signed [30:0] es_r [6], es_nxt [6];
  logic signed [61:0] prod_r, prod_nxt;
  logic signed [61:0] c_r [3], c_nxt [3];
  logic [61:0]        m_r [3], m_nxt [3];
  logic [61:0]        top_r, top_nxt;
  logic [61:0]        sum_r, sum_nxt;
  logic [63:0]        sx_r, sr_r, sb_r, sx_nxt, sr_nxt, sb_nxt;
  logic [49:0]        rem_r, dv_r, rem_nxt, dv_nxt;
  logic [17:0]        q_r, q_nxt;
  logic signed [17:0] n_r [3], n_nxt [3];
  logic signed [17:0] ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic signed [30:0] mul_a, mul_b;

  assign rd_corner = (cmd.op == OP_RDPOS) ? cmd.cnt[1:0] : cmd.k;
  assign rd_addr   = ADDR_W'(idx_r[rd_corner]);
  assign wr_addr   = (cmd.op == OP_ACC) ? ADDR_W'(idx_r[cmd.k]) : ADDR_W'(idx_r[0]);
  assign pos_we    = (cmd.op == OP_WRITE);
  assign sum_we    = pos_we || (cmd.op == OP_ACC && cmd.cnt == ACC_LAST);
  assign sum_x_wd  = pos_we ? 32'sd0 : sat_add(sum_x_q_r, n_r[0]);
  assign sum_y_wd  = pos_we ? 32'sd0 : sat_add(sum_y_q_r, n_r[1]);
  assign sum_z_wd  = pos_we ? 32'sd0 : sat_add(sum_z_q_r, n_r[2]);

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_x_mem[wr_addr] <= wx_r;
      pos_y_mem[wr_addr] <= wy_r;
      pos_z_mem[wr_addr] <= wz_r;
    end
    pos_x_q_r <= pos_x_mem[rd_addr];
    pos_y_q_r <= pos_y_mem[rd_addr];
    pos_z_q_r <= pos_z_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_x_mem[wr_addr] <= sum_x_wd;
      sum_y_mem[wr_addr] <= sum_y_wd;
      sum_z_mem[wr_addr] <= sum_z_wd;
    end
    sum_x_q_r <= sum_x_mem[rd_addr];
    sum_y_q_r <= sum_y_mem[rd_addr];
    sum_z_q_r <= sum_z_mem[rd_addr];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == OP_SQ) begin
      mul_a = {1'b0, m_r[cmd.cnt[1:0]][29:0]};
      mul_b = {1'b0, m_r[cmd.cnt[1:0]][29:0]};
    end else begin
      case (cmd.cnt[2:0])
        3'd0: begin mul_a = es_r[1]; mul_b = es_r[5]; end
        3'd1: begin mul_a = es_r[2]; mul_b = es_r[4]; end
        3'd2: begin mul_a = es_r[2]; mul_b = es_r[3]; end
        3'd3: begin mul_a = es_r[0]; mul_b = es_r[5]; end
        3'd4: begin mul_a = es_r[0]; mul_b = es_r[4]; end
        3'd5: begin mul_a = es_r[1]; mul_b = es_r[3]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    logic [32:0]      emag [6];
    logic [32:0]      etop;
    logic [32:0]      esh;
    logic [30:0]      esm;
    logic [1:0]       eshift;
    logic [CNT_W-1:0] cm1;
    logic [61:0]      cmag [3];
    logic [61:0]      ctop;
    logic [63:0]      rb;
    logic [49:0]      rem_step;
    logic [17:0]      q_step;
    logic             qbit;

    vcount_nxt = vcount_r;
    wx_nxt     = wx_r;
    wy_nxt     = wy_r;
    wz_nxt     = wz_r;
    prod_nxt   = prod_r;
    top_nxt    = top_r;
    sum_nxt    = sum_r;
    sx_nxt     = sx_r;
    sr_nxt     = sr_r;
    sb_nxt     = sb_r;
    rem_nxt    = rem_r;
    dv_nxt     = dv_r;
    q_nxt      = q_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    for (int i = 0; i < 3; i++) begin
      idx_nxt[i] = idx_r[i];
      px_nxt[i]  = px_r[i];
      py_nxt[i]  = py_r[i];
      pz_nxt[i]  = pz_r[i];
      c_nxt[i]   = c_r[i];
      m_nxt[i]   = m_r[i];
      n_nxt[i]   = n_r[i];
    end
    for (int i = 0; i < 6; i++) begin
      e_nxt[i]  = e_r[i];
      es_nxt[i] = es_r[i];
    end

    etop   = '0;
    eshift = '0;
    esh    = '0;
    esm    = '0;
    ctop   = '0;
    cm1    = cmd.cnt - 1'b1;
    rb     = sr_r + sb_r;
    for (int i = 0; i < 6; i++) begin
      emag[i] = e_r[i][32] ? (~e_r[i] + 1'b1) : e_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_r[i][61] ? (~c_r[i] + 1'b1) : c_r[i];
    end
    if (rem_r >= dv_r) begin
      rem_step = rem_r - dv_r;
      qbit     = 1'b1;
    end else begin
      rem_step = rem_r;
      qbit     = 1'b0;
    end
    q_step = {q_r[16:0], qbit};

    if (psel && penable && pwrite && paddr[2] == REG_VCOUNT) begin
      vcount_nxt = pwdata[10:0];
    end

    case (cmd.op)
      OP_LATCH: begin
        idx_nxt[0] = first_index;
        idx_nxt[1] = second_index;
        idx_nxt[2] = third_index;
        wx_nxt     = pos_x;
        wy_nxt     = pos_y;
        wz_nxt     = pos_z;
      end
      OP_RDPOS: begin
        if (cmd.cnt != '0) begin
          px_nxt[cm1[1:0]] = pos_x_q_r;
          py_nxt[cm1[1:0]] = pos_y_q_r;
          pz_nxt[cm1[1:0]] = pos_z_q_r;
        end
      end
      OP_EDGE: begin
        e_nxt[0] = $signed({px_r[1][31], px_r[1]}) - $signed({px_r[0][31], px_r[0]});
        e_nxt[1] = $signed({py_r[1][31], py_r[1]}) - $signed({py_r[0][31], py_r[0]});
        e_nxt[2] = $signed({pz_r[1][31], pz_r[1]}) - $signed({pz_r[0][31], pz_r[0]});
        e_nxt[3] = $signed({px_r[2][31], px_r[2]}) - $signed({px_r[0][31], px_r[0]});
        e_nxt[4] = $signed({py_r[2][31], py_r[2]}) - $signed({py_r[0][31], py_r[0]});
        e_nxt[5] = $signed({pz_r[2][31], pz_r[2]}) - $signed({pz_r[0][31], pz_r[0]});
      end
      OP_ESHIFT: begin
        for (int i = 0; i < 6; i++) begin
          if (emag[i] > etop) etop = emag[i];
        end
        if (etop[32]) eshift = 2'd3;
        else if (etop[31]) eshift = 2'd2;
        else if (etop[30]) eshift = 2'd1;
        else eshift = 2'd0;
        for (int i = 0; i < 6; i++) begin
          esh       = emag[i] >> eshift;
          esm       = {1'b0, esh[29:0]};
          es_nxt[i] = e_r[i][32] ? (~esm + 1'b1) : esm;
        end
      end
      OP_CROSS: begin
        prod_nxt = mul_a * mul_b;
        if (cmd.cnt != '0) begin
          if (!cm1[0]) c_nxt[cm1[2:1]] = prod_r;
          else c_nxt[cm1[2:1]] = c_r[cm1[2:1]] - prod_r;
        end
      end
      OP_RDSUM: begin
        if (cmd.cnt == RDSUM_LAST) begin
          c_nxt[0] = 62'(sum_x_q_r);
          c_nxt[1] = 62'(sum_y_q_r);
          c_nxt[2] = 62'(sum_z_q_r);
        end
      end
      OP_PREP: begin
        for (int i = 0; i < 3; i++) begin
          m_nxt[i] = cmag[i];
          if (cmag[i] > ctop) ctop = cmag[i];
        end
        top_nxt = ctop;
      end
      OP_NORM: begin
        if (top_r[61:30] != '0) begin
          top_nxt = top_r >> 1;
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] >> 1;
        end else if (!top_r[29]) begin
          top_nxt = top_r << 1;
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] << 1;
        end
      end
      OP_SQ: begin
        prod_nxt = mul_a * mul_b;
        if (cmd.cnt == '0) sum_nxt = '0;
        else sum_nxt = sum_r + prod_r;
      end
      OP_SQRT: begin
        if (cmd.cnt == '0) begin
          sx_nxt = 64'(sum_r);
          sr_nxt = '0;
          sb_nxt = 64'd1 << 62;
        end else begin
          if (sx_r >= rb) begin
            sx_nxt = sx_r - rb;
            sr_nxt = (sr_r >> 1) + sb_r;
          end else begin
            sr_nxt = sr_r >> 1;
          end
          sb_nxt = sb_r >> 2;
        end
      end
      OP_DIV: begin
        if (cmd.cnt == '0) begin
          rem_nxt = 50'({m_r[cmd.k][29:0], 16'b0}) + 50'(sr_r[31:1]);
          dv_nxt  = 50'({sr_r[31:0], 17'b0});
          q_nxt   = '0;
        end else begin
          rem_nxt = rem_step;
          dv_nxt  = dv_r >> 1;
          q_nxt   = q_step;
          if (cmd.cnt == DIV_LAST) begin
            n_nxt[cmd.k] = c_r[cmd.k][61] ? (~q_step + 1'b1) : q_step;
          end
        end
      end
      OP_OUT_N: begin
        ox_nxt = n_r[0];
        oy_nxt = n_r[1];
        oz_nxt = n_r[2];
      end
      OP_OUT_DEF: begin
        ox_nxt = '0;
        oy_nxt = ONE_Q16;
        oz_nxt = '0;
      end
      OP_OUT_ZERO: begin
        ox_nxt = '0;
        oy_nxt = '0;
        oz_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wx_r   <= wx_nxt;
    wy_r   <= wy_nxt;
    wz_r   <= wz_nxt;
    prod_r <= prod_nxt;
    top_r  <= top_nxt;
    sum_r  <= sum_nxt;
    sx_r   <= sx_nxt;
    sr_r   <= sr_nxt;
    sb_r   <= sb_nxt;
    rem_r  <= rem_nxt;
    dv_r   <= dv_nxt;
    q_r    <= q_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oz_r   <= oz_nxt;
    for (int i = 0; i < 3; i++) begin
      idx_r[i] <= idx_nxt[i];
      px_r[i]  <= px_nxt[i];
      py_r[i]  <= py_nxt[i];
      pz_r[i]  <= pz_nxt[i];
      c_r[i]   <= c_nxt[i];
      m_r[i]   <= m_nxt[i];
      n_r[i]   <= n_nxt[i];
    end
    for (int i = 0; i < 6; i++) begin
      e_r[i]  <= e_nxt[i];
      es_r[i] <= es_nxt[i];
    end
  end

  assign stat.ok_first  = idx_ok(first_index, vcount_r);
  assign stat.ok_all    = idx_ok(first_index, vcount_r) && idx_ok(second_index, vcount_r)
                          && idx_ok(third_index, vcount_r);
  assign stat.zero      = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
  assign stat.norm_done = (top_r[61:30] == '0) && top_r[29];

  assign prdata   = (paddr[2] == REG_VCOUNT) ? {21'b0, vcount_r} : 32'b0;
  assign normal_x = ox_r;
  assign normal_y = oy_r;
  assign normal_z = oz_r;

endmodule

// ===== sv/vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps
// top level: per-vertex normal accumulator built from averaged face normals
// One item at a time: busy stays high from the accepting edge until the result beat, which is
// shown for exactly one cycle on out_valid and cannot be held off. Reads and triangles are
// dominated by the 32-step square root and three 18-step restoring divisions, plus up to 31
// one-bit normalize shifts; a zero sum or zero face normal skips all of them.
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [9:0]         in_first_index,
  input  logic [9:0]         in_second_index,
  input  logic [9:0]         in_third_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z,
  output logic               out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vna_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .action     (in_action),
    .stat       (stat),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status),
    .cmd        (cmd)
  );

  vna_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .first_index  (in_first_index),
    .second_index (in_second_index),
    .third_index  (in_third_index),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pos_z        (in_pos_z),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .normal_x     (out_normal_x),
    .normal_y     (out_normal_y),
    .normal_z     (out_normal_z)
  );

  assign pready = 1'b1;

endmodule

// ===== tb/sv/vertex_normal_accumulator_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the vertex normal accumulator with a built-in normal predictor
module vertex_normal_accumulator_tb;
  import vna_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DEPTH = 1024;
  localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint unsigned NORM_LO = 64'd1 << 29;
  localparam longint unsigned NORM_HI = 64'd1 << 30;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic               st;
  } normal_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [9:0] in_first_index = '0;
  logic [9:0] in_second_index = '0;
  logic [9:0] in_third_index = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic out_valid;
  logic signed [17:0] out_normal_x;
  logic signed [17:0] out_normal_y;
  logic signed [17:0] out_normal_z;
  logic out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vertex_normal_accumulator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned model_count;
  int pos_x [DEPTH];
  int pos_y [DEPTH];
  int pos_z [DEPTH];
  int sum_x [DEPTH];
  int sum_y [DEPTH];
  int sum_z [DEPTH];
  bit written [DEPTH];
  int written_list [$];

  normal_beat_t pending_normals [$];
  int mismatches = 0;
  bit calm = 1'b0;
  longint cycles = 0;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit scale_to_unit(vec3_t c, output vec3_t n);
    longint unsigned m [3];
    longint unsigned top, sum, len, q;
    top = 0;
    sum = 0;
    n = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(c[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) return 1'b0;
    while (top >= NORM_HI) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      top >>= 1;
    end
    while (top < NORM_LO) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      top <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd65536 + len / 2) / len;
      n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic int sat_sum(int a, longint b);
    longint t;
    t = longint'(a) + b;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return int'(t);
  endfunction

  function automatic bit index_valid(logic [9:0] idx);
    return idx < model_count && idx < DEPTH;
  endfunction

  function automatic void accumulate_face(int a, int b, int c);
    longint e [6];
    longint top;
    vec3_t cr, n;
    int s;
    int corner [3];
    e[0] = longint'(pos_x[b]) - pos_x[a];
    e[1] = longint'(pos_y[b]) - pos_y[a];
    e[2] = longint'(pos_z[b]) - pos_z[a];
    e[3] = longint'(pos_x[c]) - pos_x[a];
    e[4] = longint'(pos_y[c]) - pos_y[a];
    e[5] = longint'(pos_z[c]) - pos_z[a];
    top = 0;
    s = 0;
    corner = '{a, b, c};
    for (int i = 0; i < 6; i++)
      if (longint'(magnitude(e[i])) > top) top = magnitude(e[i]);
    while (top >= longint'(NORM_HI)) begin
      top >>= 1;
      s++;
    end
    for (int i = 0; i < 6; i++)
      e[i] = e[i] < 0 ? -longint'(magnitude(e[i]) >> s) : longint'(magnitude(e[i]) >> s);
    cr[0] = e[1] * e[5] - e[2] * e[4];
    cr[1] = e[2] * e[3] - e[0] * e[5];
    cr[2] = e[0] * e[4] - e[1] * e[3];
    if (!scale_to_unit(cr, n)) return;
    foreach (corner[k]) begin
      sum_x[corner[k]] = sat_sum(sum_x[corner[k]], n[0]);
      sum_y[corner[k]] = sat_sum(sum_y[corner[k]], n[1]);
      sum_z[corner[k]] = sat_sum(sum_z[corner[k]], n[2]);
    end
  endfunction

  function automatic normal_beat_t predict_normal(logic [1:0] act, logic [9:0] i0,
                                                  logic [9:0] i1, logic [9:0] i2,
                                                  int px, int py, int pz);
    normal_beat_t r;
    vec3_t s, n;
    r = '{nx: '0, ny: '0, nz: '0, st: 1'b1};
    case (act)
      ACT_WRITE: begin
        if (index_valid(i0)) begin
          pos_x[i0] = px;
          pos_y[i0] = py;
          pos_z[i0] = pz;
          sum_x[i0] = 0;
          sum_y[i0] = 0;
          sum_z[i0] = 0;
          if (!written[i0]) written_list = {written_list, int'(i0)};
          written[i0] = 1'b1;
          r.st = 1'b0;
        end
      end
      ACT_TRI: begin
        if (index_valid(i0) && index_valid(i1) && index_valid(i2)) begin
          accumulate_face(int'(i0), int'(i1), int'(i2));
          r.st = 1'b0;
        end
      end
      ACT_READ: begin
        if (index_valid(i0)) begin
          s = '{sum_x[i0], sum_y[i0], sum_z[i0]};
          if (!scale_to_unit(s, n)) n = '{0, 65536, 0};
          r.nx = n[0][17:0];
          r.ny = n[1][17:0];
          r.nz = n[2][17:0];
          r.st = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk) begin
    normal_beat_t e;
    if (rst_n && out_valid) begin
      if (pending_normals.size() == 0) begin
        note_mismatch("unexpected beat, status", -1, out_status);
      end else begin
        e = pending_normals.pop_front();
        if (out_normal_x !== e.nx) note_mismatch("normal_x", e.nx, out_normal_x);
        if (out_normal_y !== e.ny) note_mismatch("normal_y", e.ny, out_normal_y);
        if (out_normal_z !== e.nz) note_mismatch("normal_z", e.nz, out_normal_z);
        if (out_status !== e.st) note_mismatch("status", e.st, out_status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [9:0] i0, logic [9:0] i1, logic [9:0] i2,
                           int px, int py, int pz);
    normal_beat_t expected;
    if (!calm && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_first_index <= i0;
    in_second_index <= i1;
    in_third_index <= i2;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (busy !== 1'b0);
    expected = predict_normal(act, i0, i1, i2, px, py, pz);
    pending_normals = {pending_normals, expected};
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_vertex_count(int unsigned value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_VERTEX_COUNT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    model_count = value & 32'h7FF;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[10:0] !== model_count[10:0]) note_mismatch("vertex_count readback",
                                                          model_count, prdata[10:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_coord(bit wide);
    if (wide) return int'($urandom());
    return int'($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  function automatic bit pick_vertex(output logic [9:0] idx);
    int v;
    idx = '0;
    for (int t = 0; t < 40 && written_list.size() != 0; t++) begin
      v = written_list[$urandom_range(written_list.size() - 1)];
      if (v < model_count) begin
        idx = 10'(v);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic test_reset_rejects;
    set_vertex_count(0);
    send_item(ACT_WRITE, 10'd0, 10'd0, 10'd0, 1, 2, 3);
    send_item(ACT_READ, 10'd0, 10'd0, 10'd0, 0, 0, 0);
    send_item(ACT_TRI, 10'd0, 10'd1, 10'd2, 0, 0, 0);
    send_item(ACT_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF, -1, -1, -1);
  endtask

  task automatic test_directed_cases;
    set_vertex_count(1024);
    send_item(ACT_WRITE, 10'd0, 10'd0, 10'd0, 0, 0, 0);
    send_item(ACT_WRITE, 10'd1, 10'd0, 10'd0, 32'h0001_0000, 0, 0);
    send_item(ACT_WRITE, 10'd2, 10'd0, 10'd0, 0, 32'h0001_0000, 0);
    send_item(ACT_READ, 10'd0, 10'd0, 10'd0, 0, 0, 0);
    send_item(ACT_TRI, 10'd0, 10'd1, 10'd2, 0, 0, 0);
    send_item(ACT_TRI, 10'd0, 10'd2, 10'd1, 0, 0, 0);
    send_item(ACT_READ, 10'd0, 10'd0, 10'd0, 0, 0, 0);
    send_item(ACT_TRI, 10'd0, 10'd1, 10'd2, 0, 0, 0);
    send_item(ACT_READ, 10'd1, 10'd0, 10'd0, 0, 0, 0);
    // extreme coordinates force the edge shift
    send_item(ACT_WRITE, 10'h3FF, 10'd0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_WRITE, 10'd1022, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_WRITE, 10'd1021, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_TRI, 10'h3FF, 10'd1022, 10'd1021, 0, 0, 0);
    send_item(ACT_READ, 10'h3FF, 10'd0, 10'd0, 0, 0, 0);
    // collinear corners give a zero face normal
    send_item(ACT_WRITE, 10'd3, 10'd0, 10'd0, 32'h0002_0000, 0, 0);
    send_item(ACT_TRI, 10'd0, 10'd1, 10'd3, 0, 0, 0);
    send_item(ACT_TRI, 10'd3, 10'd3, 10'd3, 0, 0, 0);
    send_item(ACT_READ, 10'd3, 10'd0, 10'd0, 0, 0, 0);
    send_item(ACT_UNUSED, 10'd0, 10'd1, 10'd2, 0, 0, 0);
    set_vertex_count(3);
    send_item(ACT_TRI, 10'd0, 10'd1, 10'd3, 0, 0, 0);
    send_item(ACT_READ, 10'd3, 10'd0, 10'd0, 0, 0, 0);
    send_item(ACT_WRITE, 10'd3, 10'd0, 10'd0, 5, 5, 5);
    send_item(ACT_READ, 10'd2, 10'd0, 10'd0, 0, 0, 0);
  endtask

  task automatic random_phase(int unsigned count, int items, bit quiet);
    int r;
    logic [9:0] a, b, c;
    bit wide;
    set_vertex_count(count);
    calm = quiet;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      wide = $urandom_range(9) == 0;
      if (r < 45 && pick_vertex(a) && pick_vertex(b) && pick_vertex(c)) begin
        send_item(ACT_TRI, a, b, c, $urandom(), $urandom(), $urandom());
      end else if (r >= 45 && r < 70 && pick_vertex(a)) begin
        send_item(ACT_READ, a, 10'($urandom()), 10'($urandom()), $urandom(), $urandom(),
                  $urandom());
      end else if (r >= 95) begin
        a = 10'($urandom());
        b = 10'($urandom());
        c = 10'($urandom());
        if ($urandom_range(1) == 0) send_item(ACT_UNUSED, a, b, c, $urandom(), 0, 0);
        else if (!index_valid(a) || !index_valid(b) || !index_valid(c))
          send_item(ACT_TRI, a, b, c, 0, 0, 0);
        else if (!index_valid(a)) send_item(ACT_READ, a, b, c, 0, 0, 0);
        else send_item(ACT_WRITE, 10'($urandom()), b, c, rand_coord(1), rand_coord(1),
                       rand_coord(1));
      end else begin
        a = count > 64 && $urandom_range(3) != 0 ? 10'($urandom_range(63)) : 10'($urandom());
        if (count != 0 && $urandom_range(7) != 0) a = 10'(a % count);
        send_item(ACT_WRITE, a, 10'($urandom()), 10'($urandom()),
                  rand_coord(wide), rand_coord(wide), rand_coord(wide));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random_meshes;
    random_phase(1024, 500, 1'b0);
    random_phase(16, 300, 1'b1);
    random_phase(3, 200, 1'b0);
    random_phase(200, 400, 1'b0);
    random_phase(0, 30, 1'b0);
    random_phase(1024, 500, 1'b0);
  endtask

  initial begin
    model_count = 0;
    foreach (written[i]) begin
      written[i] = 1'b0;
      pos_x[i] = 0;
      pos_y[i] = 0;
      pos_z[i] = 0;
      sum_x[i] = 0;
      sum_y[i] = 0;
      sum_z[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_rejects();
    test_directed_cases();
    test_random_meshes();
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vna_pkg.sv
sv/vna_ctrl.sv
sv/vna_dp.sv
sv/vertex_normal_accumulator.sv
tb/sv/vertex_normal_accumulator_tb.sv
